// File: src/dxtd_pkg.sv
// Shared types, codes and helper functions for the DXT texel decoder.
`default_nettype none

package dxtd_pkg;

   typedef enum logic [1:0] {
      FMT_DXT1_OPAQUE = 2'd0,
      FMT_DXT1_ALPHA  = 2'd1,
      FMT_DXT3        = 2'd2,
      FMT_DXT5        = 2'd3
   } format_type;

   // colour codes
   localparam logic [1:0] CCODE_C0    = 2'd0;
   localparam logic [1:0] CCODE_C1    = 2'd1;
   localparam logic [1:0] CCODE_BLACK = 2'd3;

   // DXT5 alpha codes
   localparam logic [2:0] ACODE_A0    = 3'd0;
   localparam logic [2:0] ACODE_A1    = 3'd1;
   localparam logic [2:0] ACODE_ZERO  = 3'd6;
   localparam logic [2:0] ACODE_FULL  = 3'd7;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   typedef struct packed {
      logic [1:0]  texel_x;
      logic [1:0]  texel_y;
      logic [63:0] color_block;
      logic [63:0] alpha_block;
   } request_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } texel_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

endpackage

`default_nettype wire

// File: src/dxtd_req_if.sv
// Request channel: texel position and the two halves of a compressed block.
`default_nettype none

interface dxtd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  texel_x;
   logic [1:0]  texel_y;
   logic [63:0] color_block;
   logic [63:0] alpha_block;

   modport source (output valid, output texel_x, output texel_y,
                   output color_block, output alpha_block, input ready);
   modport sink   (input valid, input texel_x, input texel_y,
                   input color_block, input alpha_block, output ready);
endinterface

`default_nettype wire

// File: src/dxtd_rsp_if.sv
// Response channel: one decoded RGBA8888 texel.
`default_nettype none

interface dxtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source (output valid, output red, output green, output blue,
                   output alpha, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input alpha, output ready);
endinterface

`default_nettype wire

// File: src/dxtd_decode.sv
// Combinational decode of one texel from a registered request.
`default_nettype none

module dxtd_decode import dxtd_pkg::*; (
   input  format_type  block_format,
   input  request_type req,
   output texel_type   texel
);

   logic [3:0]  pos;
   logic        odd;
   logic [15:0] c0;
   logic [15:0] c1;
   logic [1:0]  ccode;
   logic [15:0] colour;
   logic        is_dxt1;
   logic [7:0]  alpha_dxt1;
   logic [3:0]  nibble;
   logic [5:0]  acode_idx;
   logic [2:0]  acode;
   logic [7:0]  a0;
   logic [7:0]  a1;
   logic [7:0]  alpha_dxt5;
   logic [31:0] codes;
   logic [47:0] acodes;

   assign pos     = {req.texel_y, req.texel_x};
   assign odd     = req.texel_x[0] ^ req.texel_y[0];
   assign c0      = req.color_block[15:0];
   assign c1      = req.color_block[31:16];
   assign codes   = req.color_block[63:32];
   assign ccode   = codes[{pos, 1'b0} +: 2];
   assign is_dxt1 = (block_format == FMT_DXT1_OPAQUE) || (block_format == FMT_DXT1_ALPHA);

   // 3*pos as shift-add
   assign acode_idx = {2'b00, pos} + {1'b0, pos, 1'b0};
   assign acodes    = req.alpha_block[63:16];
   assign acode     = acodes[acode_idx +: 3];
   assign a0        = req.alpha_block[7:0];
   assign a1        = req.alpha_block[15:8];
   assign nibble    = req.alpha_block[{pos, 2'b00} +: 4];

   always_comb begin
      colour     = c0;
      alpha_dxt1 = ALPHA_OPAQUE;
      if (ccode == CCODE_C1) begin
         colour = c1;
      end else if (ccode == CCODE_BLACK && is_dxt1 && c1 > c0) begin
         colour = '0;
         if (block_format == FMT_DXT1_ALPHA) begin
            alpha_dxt1 = ALPHA_CLEAR;
         end
      end else if (ccode != CCODE_C0 && odd) begin
         colour = c1;
      end
   end

   always_comb begin
      case (acode)
         ACODE_A0:   alpha_dxt5 = a0;
         ACODE_A1:   alpha_dxt5 = a1;
         ACODE_ZERO: alpha_dxt5 = ALPHA_CLEAR;
         ACODE_FULL: alpha_dxt5 = ALPHA_OPAQUE;
         default:    alpha_dxt5 = odd ? a1 : a0;
      endcase
   end

   always_comb begin
      texel.red   = widen5(colour[15:11]);
      texel.green = widen6(colour[10:5]);
      texel.blue  = widen5(colour[4:0]);
      case (block_format)
         FMT_DXT3: texel.alpha = {nibble, nibble};
         FMT_DXT5: texel.alpha = alpha_dxt5;
         default:  texel.alpha = alpha_dxt1;
      endcase
   end

endmodule

`default_nettype wire

// File: src/dxt_texel_decoder_dithered.sv
// Top level of the DXT1/DXT3/DXT5 texel decoder without interpolation.
//
// Usage:
//  - req_chan (sink): one transfer carries a texel position (x, y) and the
//    colour and alpha halves of its 4x4 block as little-endian 64-bit words.
//  - rsp_chan (source): one transfer per request, the texel as RGBA8888,
//    in request order.
//  - csr_wr_en / csr_wr_data: writes the block format (0 DXT1 opaque,
//    1 DXT1 with alpha, 2 DXT3, 3 DXT5). Write it only while the block
//    holds no request in flight.
//
// Path: a request transfer is captured in the input register, then decoded
// into the result register, which drives rsp_chan.
// Throughput: one texel per clock while rsp_chan.ready stays high; a request
// transfer is taken in every cycle in which the input register is empty or
// the result register will be free or emptied.
// Stall: when rsp_chan.ready is low the result holds, the input register
// fills behind it and req_chan.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high): both stages empty, format DXT1 opaque.
`default_nettype none

module dxt_texel_decoder_dithered import dxtd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   dxtd_req_if.sink        req_chan,
   dxtd_rsp_if.source      rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);

   format_type  format_ff, format_in;

   logic        s1_valid_ff, s1_valid_in;
   request_type s1_req_ff, s1_req_in;
   logic        s2_valid_ff, s2_valid_in;
   texel_type   s2_texel_ff, s2_texel_in;

   logic        s2_free;
   logic        s1_free;
   texel_type   decoded;

   // Result register frees when empty or when its transfer happens now;
   // the input register frees when empty or when it moves on.
   assign s2_free = !s2_valid_ff || rsp_chan.ready;
   assign s1_free = !s1_valid_ff || s2_free;

   assign req_chan.ready = s1_free;

   always_comb begin
      format_in = csr_wr_en ? format_type'(csr_wr_data) : format_ff;

      s1_valid_in = s1_free ? req_chan.valid : s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (s1_free && req_chan.valid) begin
         s1_req_in.texel_x     = req_chan.texel_x;
         s1_req_in.texel_y     = req_chan.texel_y;
         s1_req_in.color_block = req_chan.color_block;
         s1_req_in.alpha_block = req_chan.alpha_block;
      end

      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      s2_texel_in = (s2_free && s1_valid_ff) ? decoded : s2_texel_ff;
   end

   dxtd_decode u_decode (
      .block_format (format_ff),
      .req          (s1_req_ff),
      .texel        (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= FMT_DXT1_OPAQUE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         format_ff   <= format_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      s2_texel_ff <= s2_texel_in;
   end

   assign rsp_chan.valid = s2_valid_ff;
   assign rsp_chan.red   = s2_texel_ff.red;
   assign rsp_chan.green = s2_texel_ff.green;
   assign rsp_chan.blue  = s2_texel_ff.blue;
   assign rsp_chan.alpha = s2_texel_ff.alpha;

endmodule

`default_nettype wire
